FILE: rtl/mpx_pkg.sv
// shared types, codes and constants of the multi-paxos node engine
`default_nettype none
package mpx_pkg;

  // default and limits
  localparam int SLOTS_DEF = 64;
  localparam int MAX_SITES = 16;
  localparam logic [4:0]  TALLY_MAX  = 5'd31;
  localparam logic [15:0] BALLOT_MAX = 16'hFFFF;

  // message codes, shared by input cmd and output send_kind
  localparam logic [2:0] MSG_NONE    = 3'd0;
  localparam logic [2:0] MSG_PROPOSE = 3'd0;
  localparam logic [2:0] MSG_PREPARE = 3'd1;
  localparam logic [2:0] MSG_PROMISE = 3'd2;
  localparam logic [2:0] MSG_ACCEPT  = 3'd3;
  localparam logic [2:0] MSG_ACK     = 3'd4;
  localparam logic [2:0] MSG_COMMIT  = 3'd5;
  localparam logic [2:0] MSG_RETRY   = 3'd6;

  // register indexes
  localparam logic REG_SELF_ID   = 1'b0;
  localparam logic REG_NUM_SITES = 1'b1;

  typedef struct packed {
    logic [3:0] self_id;
    logic [4:0] num_sites;
  } cfg_t;

  // slot number to slot index table, built at elaboration
  typedef logic [11:0] mod_tbl_t [64];

  function automatic mod_tbl_t build_mod_tbl(int n);
    mod_tbl_t tbl;
    int r;
    for (int s = 0; s < 64; s++) begin
      r = s;
      for (int k = 0; k < 64; k++) begin
        if (r >= n) r = r - n;
      end
      tbl[s] = 12'(r);
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mpx_in_if.sv
// input message channel
`default_nettype none
interface mpx_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  sender;
  logic [5:0]  slot;
  logic [15:0] ballot;
  logic [31:0] value;

  modport source (output valid, cmd, sender, slot, ballot, value, input ready);
  modport sink   (input valid, cmd, sender, slot, ballot, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpx_out_if.sv
// outgoing message channel
`default_nettype none
interface mpx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  send_kind;
  logic        to_all;
  logic [3:0]  dest;
  logic [5:0]  out_slot;
  logic [15:0] out_ballot;
  logic [31:0] out_value;
  logic        decided;

  modport source (output valid, send_kind, to_all, dest, out_slot, out_ballot, out_value,
                  decided, input ready);
  modport sink   (input valid, send_kind, to_all, dest, out_slot, out_ballot, out_value,
                  decided, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpx_cfg.sv
// apb-style configuration registers
`default_nettype none
module mpx_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output mpx_pkg::cfg_t     cfg
);
  import mpx_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_SELF_ID:   cfg_nxt.self_id   = cfg_pwdata[3:0];
        REG_NUM_SITES: cfg_nxt.num_sites = cfg_pwdata[4:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_id   <= 4'd1;
      cfg_r.num_sites <= 5'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_paddr[2])
      REG_SELF_ID:   cfg_prdata = {28'd0, cfg_r.self_id};
      REG_NUM_SITES: cfg_prdata = {27'd0, cfg_r.num_sites};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

FILE: rtl/mpx_slot_mem.sv
// per-slot memory with valid bits, registered read and write forwarding
`default_nettype none
module mpx_slot_mem #(
  parameter int W     = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  output logic [W-1:0]       rd_data
);
  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     mem_q_r;
  logic             vld_q_r;
  logic             fwd_r;
  logic [W-1:0]     fwd_d_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // valid bits, cleared at reset so unwritten entries read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read, bypassing a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
      fwd_r   <= wr_en && (wr_addr == rd_addr);
      fwd_d_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_d_r : (vld_q_r ? mem_q_r : '0);
endmodule
`default_nettype wire

FILE: rtl/multi_paxos_node_engine.sv
// multi-paxos node engine: proposer, acceptor and learner over a ring of log slots
//
// in_ch carries one message per transfer (local propose, prepare, promise, accept,
// ack, commit, retry). out_ch returns exactly one result per message: an
// outgoing message (send_kind 0 for none) with a decided flag.
// The cfg_ port is apb-style: self_id at 0x0, num_sites at 0x4, pready always high.
// A message accepted into the input stage register goes on to the result register,
// which drives out_ch. Throughput: one message per cycle while out_ch does not stall;
// each message does one read-modify-write of its slot entry, with the read issued at
// accept and a bypass from the write of the message ahead.
// Reset clears the round state, sets self_id 1 and num_sites 3, and clears the
// valid bits of the slot tables at once, so no clearing pass is needed.
// When out_ch stalls, the result register holds and one more message waits in
// the input stage; in_ch.ready drops only while both are full.
`default_nettype none
module multi_paxos_node_engine #(
  parameter int SLOTS = mpx_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mpx_in_if.sink           in_ch,
  mpx_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import mpx_pkg::*;

  localparam int RING  = (SLOTS < 64) ? SLOTS : 64;
  localparam int IDX_W = (RING > 1) ? $clog2(RING) : 1;
  localparam mod_tbl_t MOD_TBL = build_mod_tbl(SLOTS);

  cfg_t cfg;

  mpx_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  // handshake
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic in_acc, adv;

  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_v_nxt     = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt    = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  // input stage register
  logic [2:0]       cmd_r;
  logic [3:0]       sender_r;
  logic [5:0]       slot_r;
  logic [15:0]      ballot_r;
  logic [31:0]      value_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] in_idx;

  assign in_idx = MOD_TBL[in_ch.slot][IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.cmd;
      sender_r <= in_ch.sender;
      slot_r   <= in_ch.slot;
      ballot_r <= in_ch.ballot;
      value_r  <= in_ch.value;
      idx_r    <= in_idx;
    end
  end

  // round state
  logic [5:0]  cur_slot_r, cur_slot_nxt;
  logic [15:0] own_ballot_r, own_ballot_nxt;
  logic [31:0] own_value_r, own_value_nxt;
  logic [4:0]  prom_tally_r, prom_tally_nxt;
  logic [15:0] best_ballot_r, best_ballot_nxt;
  logic [31:0] best_value_r, best_value_nxt;

  // slot tables
  logic        pb_we, acc_we, at_we;
  logic [15:0] pb_wd, pb_rd;
  logic [47:0] acc_wd, acc_rd;
  logic [4:0]  at_wd, at_rd;
  logic [IDX_W-1:0] at_waddr;

  mpx_slot_mem #(.W(16), .DEPTH(RING), .AW(IDX_W)) u_promised (
    .clk, .rst_n, .rd_en(in_acc), .rd_addr(in_idx),
    .wr_en(pb_we), .wr_addr(idx_r), .wr_data(pb_wd), .rd_data(pb_rd)
  );

  mpx_slot_mem #(.W(48), .DEPTH(RING), .AW(IDX_W)) u_accepted (
    .clk, .rst_n, .rd_en(in_acc), .rd_addr(in_idx),
    .wr_en(acc_we), .wr_addr(idx_r), .wr_data(acc_wd), .rd_data(acc_rd)
  );

  mpx_slot_mem #(.W(5), .DEPTH(RING), .AW(IDX_W)) u_ack_tally (
    .clk, .rst_n, .rd_en(in_acc), .rd_addr(in_idx),
    .wr_en(at_we), .wr_addr(at_waddr), .wr_data(at_wd), .rd_data(at_rd)
  );

  // quorum and round arithmetic
  logic [4:0]  sites_c;
  logic [4:0]  quorum;
  logic [16:0] ballot_sum;
  logic [15:0] round_ballot;
  logic [5:0]  next_slot;
  logic [4:0]  prom_inc, ack_inc;

  assign sites_c      = ({1'b0, cfg.num_sites} > 6'(MAX_SITES)) ? 5'(MAX_SITES)
                                                                 : cfg.num_sites;
  assign quorum       = (sites_c >> 1) + 5'd1;
  assign ballot_sum   = {1'b0, own_ballot_r} + 17'(cfg.num_sites);
  assign round_ballot = (own_ballot_r == 16'd0) ? 16'(cfg.self_id)
                      : (ballot_sum[16] ? BALLOT_MAX : ballot_sum[15:0]);
  assign next_slot    = (cur_slot_r == 6'(RING - 1)) ? 6'd0 : cur_slot_r + 6'd1;
  assign prom_inc     = (prom_tally_r < TALLY_MAX) ? prom_tally_r + 5'd1 : prom_tally_r;
  assign ack_inc      = (at_rd < TALLY_MAX) ? at_rd + 5'd1 : at_rd;

  // result fields
  logic [2:0]  kind_nxt;
  logic        all_nxt;
  logic [3:0]  dest_nxt;
  logic [5:0]  oslot_nxt;
  logic [15:0] oballot_nxt;
  logic [31:0] ovalue_nxt;
  logic        dec_nxt;
  logic        open_round, learn;

  // per-message update
  always_comb begin
    kind_nxt        = MSG_NONE;
    all_nxt         = 1'b0;
    dest_nxt        = 4'd0;
    oslot_nxt       = 6'd0;
    oballot_nxt     = 16'd0;
    ovalue_nxt      = 32'd0;
    dec_nxt         = 1'b0;
    own_value_nxt   = own_value_r;
    best_ballot_nxt = best_ballot_r;
    best_value_nxt  = best_value_r;
    prom_tally_nxt  = prom_tally_r;
    pb_we           = 1'b0;
    pb_wd           = ballot_r;
    acc_we          = 1'b0;
    acc_wd          = {ballot_r, value_r};
    at_we           = 1'b0;
    at_wd           = ack_inc;
    at_waddr        = idx_r;
    open_round      = 1'b0;
    learn           = 1'b0;
    case (cmd_r)
      MSG_PROPOSE: begin
        own_value_nxt = value_r;
        open_round    = 1'b1;
      end
      MSG_PREPARE: begin
        dest_nxt  = sender_r;
        oslot_nxt = slot_r;
        if (ballot_r > pb_rd) begin
          pb_we       = 1'b1;
          kind_nxt    = MSG_PROMISE;
          oballot_nxt = acc_rd[47:32];
          ovalue_nxt  = acc_rd[31:0];
        end else begin
          kind_nxt = MSG_RETRY;
        end
      end
      MSG_PROMISE: begin
        if (slot_r == cur_slot_r && own_ballot_r != 16'd0 && prom_tally_r < quorum) begin
          if (ballot_r == 16'd0) begin
            if (best_ballot_r <= own_ballot_r) begin
              best_ballot_nxt = own_ballot_r;
              best_value_nxt  = own_value_r;
            end
          end else if (best_ballot_r < ballot_r) begin
            best_ballot_nxt = ballot_r;
            best_value_nxt  = value_r;
          end
          prom_tally_nxt = prom_inc;
          if (prom_inc == quorum) begin
            kind_nxt    = MSG_ACCEPT;
            all_nxt     = 1'b1;
            oslot_nxt   = cur_slot_r;
            oballot_nxt = own_ballot_r;
            ovalue_nxt  = best_value_nxt;
          end
        end
      end
      MSG_ACCEPT: begin
        if (ballot_r >= pb_rd) begin
          acc_we      = 1'b1;
          pb_we       = 1'b1;
          kind_nxt    = MSG_ACK;
          dest_nxt    = sender_r;
          oslot_nxt   = slot_r;
          oballot_nxt = ballot_r;
          ovalue_nxt  = value_r;
        end
      end
      MSG_ACK: begin
        if (at_rd < quorum) begin
          at_we = 1'b1;
          if (ack_inc == quorum) begin
            kind_nxt   = MSG_COMMIT;
            all_nxt    = 1'b1;
            oslot_nxt  = slot_r;
            ovalue_nxt = value_r;
            dec_nxt    = 1'b1;
            learn      = 1'b1;
          end
        end
      end
      MSG_COMMIT: begin
        oslot_nxt  = slot_r;
        ovalue_nxt = value_r;
        dec_nxt    = 1'b1;
        learn      = 1'b1;
      end
      MSG_RETRY: begin
        open_round = (slot_r == cur_slot_r) && (own_ballot_r != 16'd0);
      end
      default: begin
        kind_nxt = MSG_NONE;
      end
    endcase

    // a new round clears the tally state and the current slot's ack count
    own_ballot_nxt = own_ballot_r;
    if (open_round) begin
      own_ballot_nxt  = round_ballot;
      prom_tally_nxt  = 5'd0;
      best_ballot_nxt = 16'd0;
      best_value_nxt  = 32'd0;
      at_we           = 1'b1;
      at_wd           = 5'd0;
      at_waddr        = cur_slot_r[IDX_W-1:0];
      kind_nxt        = MSG_PREPARE;
      all_nxt         = 1'b1;
      oslot_nxt       = cur_slot_r;
      oballot_nxt     = round_ballot;
    end

    cur_slot_nxt = (learn && slot_r == cur_slot_r) ? next_slot : cur_slot_r;

    // no state changes unless the stage advances
    if (!adv) begin
      pb_we  = 1'b0;
      acc_we = 1'b0;
      at_we  = 1'b0;
    end
  end

  // control and round state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      cur_slot_r    <= 6'd0;
      own_ballot_r  <= 16'd0;
      own_value_r   <= 32'd0;
      prom_tally_r  <= 5'd0;
      best_ballot_r <= 16'd0;
      best_value_r  <= 32'd0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        cur_slot_r    <= cur_slot_nxt;
        own_ballot_r  <= own_ballot_nxt;
        own_value_r   <= own_value_nxt;
        prom_tally_r  <= prom_tally_nxt;
        best_ballot_r <= best_ballot_nxt;
        best_value_r  <= best_value_nxt;
      end
    end
  end

  // result register
  logic [2:0]  kind_r;
  logic        all_r;
  logic [3:0]  dest_r;
  logic [5:0]  oslot_r;
  logic [15:0] oballot_r;
  logic [31:0] ovalue_r;
  logic        dec_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r    <= kind_nxt;
      all_r     <= all_nxt;
      dest_r    <= dest_nxt;
      oslot_r   <= oslot_nxt;
      oballot_r <= oballot_nxt;
      ovalue_r  <= ovalue_nxt;
      dec_r     <= dec_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.send_kind  = kind_r;
  assign out_ch.to_all     = all_r;
  assign out_ch.dest       = dest_r;
  assign out_ch.out_slot   = oslot_r;
  assign out_ch.out_ballot = oballot_r;
  assign out_ch.out_value  = ovalue_r;
  assign out_ch.decided    = dec_r;

  // checks
  a_ready_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_slot_r} < 7'(RING))
    else $error("current slot outside the ring");

  a_ballot_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> own_ballot_r >= $past(own_ballot_r))
    else $error("own ballot went down");

  a_decided_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && dec_r) |-> (kind_r == MSG_COMMIT || kind_r == MSG_NONE))
    else $error("decided set on a non-commit result");
endmodule
`default_nettype wire
